// ===== rtl/black_frame_detector_core_defines.svh =====
// ----------------------------------------------------------------------------
// black frame detector assertion macros
// shared property forms, sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef BLACK_FRAME_DETECTOR_CORE_DEFINES_SVH
`define BLACK_FRAME_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define BFD_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("black frame detector: same-cycle check failed");

// next-cycle implication
`define BFD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("black frame detector: next-cycle check failed");

`endif

// ===== rtl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// constants and types for the black frame detector
// ----------------------------------------------------------------------------
package bfd_pkg;

  // default frame size limit and sampling grid
  localparam int MAX_DIM_DEF  = 4096;
  localparam int GRID_DIV_DEF = 16;

  // register port
  localparam int CFG_DATA_W = 13;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // counters and luma
  localparam int COUNT_W    = 10;
  localparam int COUNT_MAX  = 1023;
  localparam int LUMA_W     = 15;
  localparam int W_RED      = 30;
  localparam int W_GREEN    = 59;
  localparam int W_BLUE     = 11;
  localparam int DARK_LIMIT = 800;

  // dark fraction test: dark * PCT_SCALE >= samples * PCT_DARK
  localparam int PCT_SCALE = 100;
  localparam int PCT_DARK  = 95;
  localparam int PCT_W     = COUNT_W + 7;

  // weighted color sum of one bgrx pixel
  function automatic logic [LUMA_W-1:0] luma_sum(input logic [31:0] px);
    logic [LUMA_W-1:0] b;
    logic [LUMA_W-1:0] g;
    logic [LUMA_W-1:0] r;
    b = LUMA_W'(px[7:0]);
    g = LUMA_W'(px[15:8]);
    r = LUMA_W'(px[23:16]);
    return r * LUMA_W'(W_RED) + g * LUMA_W'(W_GREEN) + b * LUMA_W'(W_BLUE);
  endfunction

endpackage

// ===== rtl/black_frame_detector_core.sv =====
// ----------------------------------------------------------------------------
// black_frame_detector_core
// samples a grid of pixels per frame and flags frames that are mostly black
// ----------------------------------------------------------------------------
// pixel channel: pixel_valid / pixel_ready carry one 32-bit bgrx pixel per
//   beat in raster order; frame size comes from frame_width / frame_height
// result channel: result_valid / result_ready carry one beat per frame
//   (mostly_dark, sample_total, dark_total), issued for the frame's last pixel
// throughput: one pixel per clock while pixel_ready holds; the position and
//   luma logic runs in the accept cycle, the counters one stage later
// result path: the last pixel's flags pass through the middle stage, and
//   result_valid is registered from them once the output is free
// stall: while a result waits, pixels keep flowing; only the next frame's
//   last pixel is held in the middle stage, and pixel_ready drops behind it
// config: apb writes at byte 0 (width) and 4 (height); the derived limits and
//   sampling steps are registered on the write, so pixels may follow at once
// reset: rst clears position, counters and both stages; the frame size
//   returns to 1 x 1
// ----------------------------------------------------------------------------
`include "black_frame_detector_core_defines.svh"

module black_frame_detector_core
  import bfd_pkg::*;
#(
  parameter int MAX_DIM  = MAX_DIM_DEF,
  parameter int GRID_DIV = GRID_DIV_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // apb
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // pixels
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  logic [31:0]           pixel_word,
  // results
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic                  mostly_dark,
  output logic [COUNT_W-1:0]    sample_total,
  output logic [COUNT_W-1:0]    dark_total
);

  localparam int POS_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int STEP_MAX = (MAX_DIM / GRID_DIV > 1) ? MAX_DIM / GRID_DIV : 1;
  localparam int PH_W     = (STEP_MAX > 1) ? $clog2(STEP_MAX) : 1;
  localparam int STEP_W   = $clog2(STEP_MAX + 1);
  // reciprocal for dim / GRID_DIV, exact for every dim below 2**DIM_W
  localparam int DIV_SH   = DIM_W + $clog2(GRID_DIV);
  localparam int DIV_MUL  = ((1 << DIV_SH) + GRID_DIV - 1) / GRID_DIV;
  localparam int PROD_W   = DIM_W + DIV_SH + 1;

  // configuration
  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic [DIM_W-1:0]      width_lim;
  logic [DIM_W-1:0]      height_lim;
  logic [STEP_W-1:0]     step_x;
  logic [STEP_W-1:0]     step_y;

  logic                  cfg_wr;
  reg_idx_t              cfg_idx;
  logic [CFG_DATA_W-1:0] wr_dim;
  logic [31:0]           wr_ext;
  logic [DIM_W-1:0]      wr_lim;
  logic [PROD_W-1:0]     wr_prod;
  logic [PROD_W-1:0]     wr_quot;
  logic [STEP_W-1:0]     wr_step;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign wr_dim  = pwdata[CFG_DATA_W-1:0];
  assign wr_ext  = 32'(wr_dim);

  always_comb begin
    if (wr_dim == '0) begin
      wr_lim = DIM_W'(1);
    end else if (wr_ext > 32'(MAX_DIM)) begin
      wr_lim = DIM_W'(MAX_DIM);
    end else begin
      wr_lim = DIM_W'(wr_ext);
    end
    wr_prod = PROD_W'(wr_lim) * PROD_W'(DIV_MUL);
    wr_quot = wr_prod >> DIV_SH;
    wr_step = (wr_quot == '0) ? STEP_W'(1) : STEP_W'(wr_quot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_DATA_W'(1);
      frame_height <= CFG_DATA_W'(1);
      width_lim    <= DIM_W'(1);
      height_lim   <= DIM_W'(1);
      step_x       <= STEP_W'(1);
      step_y       <= STEP_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH: begin
          frame_width <= wr_dim;
          width_lim   <= wr_lim;
          step_x      <= wr_step;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= wr_dim;
          height_lim   <= wr_lim;
          step_y       <= wr_step;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // position tracking, done in the accept cycle
  logic [POS_W-1:0] column_pos;
  logic [POS_W-1:0] row_pos;
  logic [PH_W-1:0]  column_phase;
  logic [PH_W-1:0]  row_phase;

  logic             pixel_beat;
  logic [DIM_W:0]   col_inc;
  logic [DIM_W:0]   row_inc;
  logic [STEP_W:0]  colph_inc;
  logic [STEP_W:0]  rowph_inc;
  logic             row_end;
  logic             frame_end;
  logic             sampled;
  logic             dark;

  assign pixel_beat = pixel_valid && pixel_ready;
  assign col_inc    = (DIM_W+1)'(column_pos) + (DIM_W+1)'(1);
  assign row_inc    = (DIM_W+1)'(row_pos) + (DIM_W+1)'(1);
  assign colph_inc  = (STEP_W+1)'(column_phase) + (STEP_W+1)'(1);
  assign rowph_inc  = (STEP_W+1)'(row_phase) + (STEP_W+1)'(1);
  assign row_end    = col_inc >= (DIM_W+1)'(width_lim);
  assign frame_end  = row_end && (row_inc >= (DIM_W+1)'(height_lim));
  assign sampled    = (column_phase == '0) && (row_phase == '0);
  assign dark       = luma_sum(pixel_word) < LUMA_W'(DARK_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos   <= '0;
      row_pos      <= '0;
      column_phase <= '0;
      row_phase    <= '0;
    end else if (pixel_beat) begin
      if (frame_end) begin
        column_pos   <= '0;
        row_pos      <= '0;
        column_phase <= '0;
        row_phase    <= '0;
      end else if (row_end) begin
        column_pos   <= '0;
        column_phase <= '0;
        row_pos      <= POS_W'(row_inc);
        row_phase    <= (rowph_inc >= (STEP_W+1)'(step_y)) ? '0 : PH_W'(rowph_inc);
      end else begin
        column_pos   <= POS_W'(col_inc);
        column_phase <= (colph_inc >= (STEP_W+1)'(step_x)) ? '0 : PH_W'(colph_inc);
      end
    end
  end

  // middle stage: per-pixel flags
  logic s1_valid;
  logic s1_sample;
  logic s1_dark;
  logic s1_last;
  logic s1_adv;
  logic out_free;

  assign out_free    = !result_valid || result_ready;
  assign s1_adv      = s1_valid && (!s1_last || out_free);
  assign pixel_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_beat) begin
      s1_sample <= sampled;
      s1_dark   <= sampled && dark;
      s1_last   <= frame_end;
    end
  end

  // counters and result register
  logic [COUNT_W-1:0] sample_count;
  logic [COUNT_W-1:0] dark_count;
  logic [COUNT_W-1:0] sample_count_next;
  logic [COUNT_W-1:0] dark_count_next;
  logic [PCT_W-1:0]   dark_pct;
  logic [PCT_W-1:0]   limit_pct;

  always_comb begin
    sample_count_next = sample_count;
    dark_count_next   = dark_count;
    if (s1_sample && sample_count != COUNT_W'(COUNT_MAX)) begin
      sample_count_next = sample_count + COUNT_W'(1);
    end
    if (s1_dark && dark_count != COUNT_W'(COUNT_MAX)) begin
      dark_count_next = dark_count + COUNT_W'(1);
    end
    dark_pct  = PCT_W'(dark_count_next) * PCT_W'(PCT_SCALE);
    limit_pct = PCT_W'(sample_count_next) * PCT_W'(PCT_DARK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      dark_count   <= '0;
    end else if (s1_adv) begin
      if (s1_last) begin
        sample_count <= '0;
        dark_count   <= '0;
      end else begin
        sample_count <= sample_count_next;
        dark_count   <= dark_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      mostly_dark  <= dark_pct >= limit_pct;
      sample_total <= sample_count_next;
      dark_total   <= dark_count_next;
    end
  end

  // checks
  `BFD_ASSERT_IMP(a_col_phase_home, column_pos == '0, column_phase == '0)
  `BFD_ASSERT_IMP(a_row_phase_home, row_pos == '0, row_phase == '0)
  `BFD_ASSERT_IMP(a_totals_sane, result_valid, dark_total <= sample_total && sample_total != '0)
  `BFD_ASSERT_NEXT(a_clear_on_frame, s1_adv && s1_last, sample_count == '0 && dark_count == '0)
  `BFD_ASSERT_IMP(a_result_source, $rose(result_valid), $past(s1_adv && s1_last))

endmodule
